@@ hdl/pidc_pkg.sv @@
// Shared types and constants of the pixel implant/decay correlator.
package pidc_pkg;

  localparam int GRID_DEF       = 40;
  localparam int STAMP_BITS_DEF = 48;

  localparam int FUNC_W    = 2;
  localparam int XY_W      = 6;
  localparam int STAMP_W   = 48;
  localparam int VAL16_W   = 16;
  localparam int WINDOW_W  = 40;
  localparam int COEF_W    = 32;
  localparam int ELAPSED_W = 40;
  localparam int CFG_IDX_W = 2;

  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 120;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = 40'd1000000000;
  localparam logic [COEF_W-1:0]   COEF0_RST  = 32'd0;
  localparam logic [COEF_W-1:0]   COEF1_RST  = 32'd65536;
  localparam logic [COEF_W-1:0]   COEF2_RST  = 32'd0;

  localparam int TOF_STAGES = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_IMPLANT = 2'd0,
    FUNC_DECAY   = 2'd1,
    FUNC_FLUSH   = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_COEF0  = 2'd1,
    CFG_COEF1  = 2'd2,
    CFG_COEF2  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_CALC,
    ST_EMIT
  } state_e;

  localparam logic KIND_DECAY  = 1'b0;
  localparam logic KIND_CLOSED = 1'b1;

endpackage

@@ hdl/pixel_implant_decay_correlator.sv @@
// Top level of the pixel implant/decay correlator.
// Each pixel keeps its implant, decay tally and blacklist timer in one entry of a
// single-port-read pixel RAM; an event reads its entry, decides, and writes it back
// in the next cycle. An event with a report then goes through evaluation, the 4-stage
// TOF correction and the output load, plus any wait on the output, before the next
// event is taken. After reset a clearing pass zeroes all GRID*GRID entries (1600 by
// default) of the pixel RAM; no event is taken during it, configuration writes are.
module pixel_implant_decay_correlator import pidc_pkg::*; #(
  parameter int GRID       = GRID_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // pixel_x, pixel_y, stamp, raw_tof, implant_energy, zero pad
  input  logic [S_TDATA_W-1:0]   s_axis_tdata_i,
  // func
  input  logic [FUNC_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // out_x, out_y, elapsed, corrected_tof, stored_energy, decays_seen, zero pad
  output logic [M_TDATA_W-1:0]   m_axis_tdata_o,
  // kind
  output logic                   m_axis_tuser_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [WINDOW_W-1:0]    cfg_data_i
);

  localparam int CELLS   = GRID * GRID;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ENTRY_W = 2 * STAMP_BITS + 3 * VAL16_W + 2;
  localparam int CMP_W   = (STAMP_BITS > WINDOW_W) ? STAMP_BITS : WINDOW_W;
  localparam logic [VAL16_W-1:0] TALLY_MAX = '1;

  state_e state_q, state_d;

  logic [WINDOW_W-1:0]    window_q;
  logic signed [COEF_W-1:0] coef0_q, coef1_q, coef2_q;

  logic [ADDR_W-1:0]     clr_cnt_q;
  logic                  clr_done;

  // item fields
  logic [XY_W-1:0]       in_x, in_y;
  logic [STAMP_W-1:0]    in_stamp;
  logic [VAL16_W-1:0]    in_tof, in_energy;
  func_e                 in_func;
  logic                  in_ok, s_accept;
  logic [ADDR_W-1:0]     in_cell;

  func_e                 func_q;
  logic [XY_W-1:0]       x_q, y_q;
  logic [STAMP_BITS-1:0] now_q;
  logic [VAL16_W-1:0]    tof_q, energy_q;
  logic [ADDR_W-1:0]     cell_q;

  // ram
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata, new_entry;

  logic                  e_imp_live, e_blk_live;
  logic [STAMP_BITS-1:0] e_imp_stamp, e_blk_stamp;
  logic [VAL16_W-1:0]    e_tof, e_energy, e_tally;

  // evaluation
  logic                  rep_d, rep_kind_d;
  logic [ELAPSED_W-1:0]  rep_elapsed_d;
  logic [VAL16_W-1:0]    rep_decays_d;
  logic                  rep_kind_q;
  logic [ELAPSED_W-1:0]  rep_elapsed_q;
  logic [VAL16_W-1:0]    rep_energy_q, rep_decays_q;

  logic                  tof_start, tof_vld;
  logic signed [COEF_W-1:0] tof_res;

  logic                  out_free, out_load;
  logic                  m_tvalid_q;
  logic                  out_kind_q;
  logic [XY_W-1:0]       out_x_q, out_y_q;
  logic [ELAPSED_W-1:0]  out_elapsed_q;
  logic [COEF_W-1:0]     out_tof_q;
  logic [VAL16_W-1:0]    out_energy_q, out_decays_q;

  // input unpacking
  assign in_x      = s_axis_tdata_i[5:0];
  assign in_y      = s_axis_tdata_i[11:6];
  assign in_stamp  = s_axis_tdata_i[59:12];
  assign in_tof    = s_axis_tdata_i[75:60];
  assign in_energy = s_axis_tdata_i[91:76];
  assign in_func   = func_e'(s_axis_tuser_i);

  always_comb begin
    unique case (in_func)
      FUNC_IMPLANT, FUNC_DECAY, FUNC_FLUSH: in_ok = 1'b1;
      default:                              in_ok = 1'b0;
    endcase
    if (({1'b0, in_x} >= 7'(GRID)) || ({1'b0, in_y} >= 7'(GRID))) begin
      in_ok = 1'b0;
    end
  end

  assign in_cell  = ADDR_W'(in_x) * ADDR_W'(GRID) + ADDR_W'(in_y);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign clr_done = (clr_cnt_q == ADDR_W'(CELLS - 1));
  assign out_free = !m_tvalid_q || m_axis_tready_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RST;
      coef0_q  <= COEF0_RST;
      coef1_q  <= COEF1_RST;
      coef2_q  <= COEF2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW: window_q <= cfg_data_i;
        CFG_COEF0:  coef0_q  <= cfg_data_i[COEF_W-1:0];
        CFG_COEF1:  coef1_q  <= cfg_data_i[COEF_W-1:0];
        CFG_COEF2:  coef2_q  <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (s_accept && in_ok) state_d = ST_EVAL;
      ST_EVAL:  state_d = rep_d ? ST_CALC : ST_IDLE;
      ST_CALC:  if (tof_vld) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_re          = 1'b0;
    ram_we          = 1'b0;
    tof_start       = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ram_re          = s_axis_tvalid_i;
      end
      ST_EVAL: begin
        ram_we    = 1'b1;
        tof_start = rep_d;
      end
      ST_CALC: ;
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      func_q   <= in_func;
      x_q      <= in_x;
      y_q      <= in_y;
      now_q    <= STAMP_BITS'(in_stamp);
      tof_q    <= in_tof;
      energy_q <= in_energy;
      cell_q   <= in_cell;
    end
  end

  pidc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_cell),
    .rdata_o (ram_rdata)
  );

  assign {e_blk_live, e_blk_stamp, e_tally, e_energy, e_tof, e_imp_stamp, e_imp_live} =
    ram_rdata;

  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : cell_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : new_entry;

  // read-modify-write of one pixel entry
  always_comb begin
    logic [STAMP_BITS-1:0] imp_diff, blk_diff;
    logic                  imp_aged, blk_aged, live1, blk1;
    logic                  n_imp_live, n_blk_live;
    logic [STAMP_BITS-1:0] n_imp_stamp, n_blk_stamp;
    logic [VAL16_W-1:0]    n_tof, n_energy, n_tally;

    imp_diff = now_q - e_imp_stamp;
    blk_diff = now_q - e_blk_stamp;
    imp_aged = e_imp_live && (now_q >= e_imp_stamp) &&
               (CMP_W'(imp_diff) > CMP_W'(window_q));
    blk_aged = e_blk_live && (now_q >= e_blk_stamp) &&
               (CMP_W'(blk_diff) > CMP_W'(window_q));
    live1    = e_imp_live && !imp_aged;
    blk1     = e_blk_live && !blk_aged;

    n_imp_live  = live1;
    n_imp_stamp = e_imp_stamp;
    n_tof       = e_tof;
    n_energy    = e_energy;
    n_tally     = imp_aged ? '0 : e_tally;
    n_blk_live  = blk1;
    n_blk_stamp = e_blk_stamp;

    rep_d         = imp_aged;
    rep_kind_d    = KIND_CLOSED;
    rep_elapsed_d = '0;
    rep_decays_d  = e_tally;

    unique case (func_q)
      FUNC_FLUSH: begin
        rep_d      = e_imp_live;
        n_imp_live = 1'b0;
        n_tally    = '0;
        n_blk_live = 1'b0;
      end
      FUNC_DECAY: begin
        if (live1 && (now_q >= e_imp_stamp)) begin
          n_tally       = (e_tally == TALLY_MAX) ? e_tally : e_tally + 1'b1;
          rep_d         = 1'b1;
          rep_kind_d    = KIND_DECAY;
          rep_elapsed_d = ELAPSED_W'(imp_diff);
          rep_decays_d  = n_tally;
        end
      end
      FUNC_IMPLANT: begin
        if (blk1) begin
          n_blk_stamp = now_q;
        end else if (live1) begin
          n_imp_live  = 1'b0;
          n_tally     = '0;
          n_blk_live  = 1'b1;
          n_blk_stamp = now_q;
        end else begin
          n_imp_live  = 1'b1;
          n_imp_stamp = now_q;
          n_tof       = tof_q;
          n_energy    = energy_q;
          n_tally     = '0;
        end
      end
      default: ;
    endcase

    new_entry = {n_blk_live, n_blk_stamp, n_tally, n_energy, n_tof, n_imp_stamp,
                 n_imp_live};
  end

  always_ff @(posedge clk_i) begin
    if (tof_start) begin
      rep_kind_q    <= rep_kind_d;
      rep_elapsed_q <= rep_elapsed_d;
      rep_energy_q  <= e_energy;
      rep_decays_q  <= rep_decays_d;
    end
  end

  pidc_tof u_tof (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (tof_start),
    .raw_tof_i (e_tof),
    .coef0_i   (coef0_q),
    .coef1_i   (coef1_q),
    .coef2_i   (coef2_q),
    .vld_o     (tof_vld),
    .tof_o     (tof_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q    <= rep_kind_q;
      out_x_q       <= x_q;
      out_y_q       <= y_q;
      out_elapsed_q <= rep_elapsed_q;
      out_tof_q     <= tof_res;
      out_energy_q  <= rep_energy_q;
      out_decays_q  <= rep_decays_q;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {4'd0, out_decays_q, out_energy_q, out_tof_q, out_elapsed_q,
                            out_y_q, out_x_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tof_vld |-> (state_q == ST_CALC))
    else $error("tof result outside calc");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("transfer taken during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && in_ok) |=> (state_q == ST_EVAL) && ram_we)
    else $error("accepted event not written back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_EMIT) && $past(state_q) != ST_IDLE)
    else $error("output load outside emit");

endmodule

@@ hdl/pidc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pidc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/pidc_tof.sv @@
// Pipelined quadratic TOF correction with floor and 32-bit saturation.
module pidc_tof import pidc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [VAL16_W-1:0]       raw_tof_i,
  input  logic signed [COEF_W-1:0] coef0_i,
  input  logic signed [COEF_W-1:0] coef1_i,
  input  logic signed [COEF_W-1:0] coef2_i,
  output logic                     vld_o,
  output logic signed [COEF_W-1:0] tof_o
);

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  logic [TOF_STAGES-1:0]    vld_q;
  logic [VAL16_W-1:0]       t_q;
  logic [31:0]              sq_q;
  logic signed [48:0]       hi_q, m2_q, m1_q, hi2_q;
  logic signed [50:0]       lo_q;
  logic signed [51:0]       sum_r;
  logic signed [COEF_W-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOF_STAGES-2:0], start_i};
    end
  end

  assign sum_r = 52'(hi2_q) + 52'(lo_q >>> 16);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q  <= raw_tof_i;
      sq_q <= raw_tof_i * raw_tof_i;
    end
    if (vld_q[0]) begin
      hi_q <= coef2_i * $signed({1'b0, sq_q[31:16]});
      m2_q <= coef2_i * $signed({1'b0, sq_q[15:0]});
      m1_q <= coef1_i * $signed({1'b0, t_q});
    end
    if (vld_q[1]) begin
      hi2_q <= hi_q;
      lo_q  <= 51'(m2_q) + 51'(m1_q) + 51'(coef0_i);
    end
    if (vld_q[2]) begin
      if (sum_r > SAT_MAX) begin
        res_q <= SAT_MAX[COEF_W-1:0];
      end else if (sum_r < SAT_MIN) begin
        res_q <= SAT_MIN[COEF_W-1:0];
      end else begin
        res_q <= sum_r[COEF_W-1:0];
      end
    end
  end

  assign vld_o = vld_q[TOF_STAGES-1];
  assign tof_o = res_q;

endmodule

@@ sim/pixel_implant_decay_correlator_test.sv @@
// Testbench: pixel implant/decay correlator checked against a behavioral per-pixel model.
module pixel_implant_decay_correlator_test;
  import pidc_pkg::*;

  localparam int CELLS = GRID_DEF * GRID_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_SHOWN = 10;
  localparam int STEADY_DECAYS = 40;
  localparam int HOT = 6;

  typedef struct packed {
    logic                 kind;
    logic [XY_W-1:0]      x;
    logic [XY_W-1:0]      y;
    logic [ELAPSED_W-1:0] elapsed;
    logic [COEF_W-1:0]    tof;
    logic [VAL16_W-1:0]   energy;
    logic [VAL16_W-1:0]   seen;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]    s_tuser = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  cfg_idx_e             cfg_idx = CFG_WINDOW;
  logic [WINDOW_W-1:0]  cfg_data = '0;

  // Mirror of the block's registers and pixel memory
  logic [WINDOW_W-1:0]      window_q = WINDOW_RST;
  logic signed [COEF_W-1:0] coef0_q = COEF0_RST;
  logic signed [COEF_W-1:0] coef1_q = COEF1_RST;
  logic signed [COEF_W-1:0] coef2_q = COEF2_RST;
  bit                       imp_live [CELLS];
  bit [STAMP_W-1:0]         imp_stamp [CELLS];
  bit [VAL16_W-1:0]         imp_tof [CELLS];
  bit [VAL16_W-1:0]         imp_energy [CELLS];
  bit [VAL16_W-1:0]         tally [CELLS];
  bit                       blk_live [CELLS];
  bit [STAMP_W-1:0]         blk_stamp [CELLS];

  report_t pending_reports [$];
  report_t got, want;

  int unsigned cycle_count = 0;
  int unsigned events_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned decay_reports = 0;
  int unsigned closed_reports = 0;
  int unsigned mismatches = 0;

  logic [STAMP_W-1:0] stamp_now = 48'd1000;
  logic [XY_W-1:0]    hot_x [HOT];
  logic [XY_W-1:0]    hot_y [HOT];
  int                 burst_left = 0;
  bit                 tx_steady = 1'b0;
  bit                 rx_free = 1'b0;
  int                 hold_req = 0;
  int                 hold_left = 0;
  int                 rx_mode = 0;
  int                 rx_left = 0;
  int unsigned        rx_tick = 0;

  pixel_implant_decay_correlator #(
    .GRID       (GRID_DEF),
    .STAMP_BITS (STAMP_BITS_DEF)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               pending_reports.size());
      $display("pixel_implant_decay_correlator: mismatch");
      $finish;
    end
  end

  function automatic logic [COEF_W-1:0] correct_tof(input logic [VAL16_W-1:0] raw);
    logic signed [95:0] t, k0, k1, k2, acc;
    longint q;
    t = $signed({80'd0, raw});
    k0 = coef0_q;
    k1 = coef1_q;
    k2 = coef2_q;
    acc = k2 * t * t + k1 * t + k0;
    q = acc[79:16];
    if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic bit aged_out(input logic [STAMP_W-1:0] now, input logic [STAMP_W-1:0] then);
    return now >= then && (now - then) > {{(STAMP_W-WINDOW_W){1'b0}}, window_q};
  endfunction

  function automatic void push_report(input logic kind, input logic [XY_W-1:0] px, py,
                                      input logic [ELAPSED_W-1:0] el, input int pix);
    report_t r;
    r.kind    = kind;
    r.x       = px;
    r.y       = py;
    r.elapsed = el;
    r.tof     = correct_tof(imp_tof[pix]);
    r.energy  = imp_energy[pix];
    r.seen    = tally[pix];
    pending_reports.push_back(r);
  endfunction

  function automatic void correlate_event(input logic [FUNC_W-1:0] fn,
                                          input logic [XY_W-1:0] px, py,
                                          input logic [STAMP_W-1:0] now,
                                          input logic [VAL16_W-1:0] tof, energy);
    int pix;
    bit closed;
    logic [STAMP_W-1:0] dt;
    closed = 1'b0;
    if (fn == FUNC_UNUSED || px >= GRID_DEF || py >= GRID_DEF) return;
    pix = int'(px) * GRID_DEF + int'(py);
    if (fn == FUNC_FLUSH) begin
      if (imp_live[pix]) push_report(KIND_CLOSED, px, py, '0, pix);
      imp_live[pix] = 1'b0;
      tally[pix] = '0;
      blk_live[pix] = 1'b0;
      return;
    end
    if (imp_live[pix] && aged_out(now, imp_stamp[pix])) begin
      push_report(KIND_CLOSED, px, py, '0, pix);
      closed = 1'b1;
      imp_live[pix] = 1'b0;
      tally[pix] = '0;
    end
    if (blk_live[pix] && aged_out(now, blk_stamp[pix])) blk_live[pix] = 1'b0;
    if (fn == FUNC_DECAY) begin
      if (!closed && imp_live[pix] && now >= imp_stamp[pix]) begin
        dt = now - imp_stamp[pix];
        if (tally[pix] != 16'hFFFF) tally[pix]++;
        push_report(KIND_DECAY, px, py, dt[ELAPSED_W-1:0], pix);
      end
      return;
    end
    if (blk_live[pix]) begin
      blk_stamp[pix] = now;
    end else if (imp_live[pix]) begin
      imp_live[pix] = 1'b0;
      tally[pix] = '0;
      blk_live[pix] = 1'b1;
      blk_stamp[pix] = now;
    end else begin
      imp_live[pix] = 1'b1;
      imp_stamp[pix] = now;
      imp_tof[pix] = tof;
      imp_energy[pix] = energy;
      tally[pix] = '0;
    end
  endfunction

  function automatic string report_text(input report_t r);
    return $sformatf("kind=%0d x=%0d y=%0d elapsed=%0d tof=%0d energy=%0d seen=%0d",
                     r.kind, r.x, r.y, r.elapsed, $signed(r.tof), r.energy, r.seen);
  endfunction

  // Output checker
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      got.kind    = m_tuser;
      got.x       = m_tdata[5:0];
      got.y       = m_tdata[11:6];
      got.elapsed = m_tdata[51:12];
      got.tof     = m_tdata[83:52];
      got.energy  = m_tdata[99:84];
      got.seen    = m_tdata[115:100];
      reports_seen++;
      if (got.kind == KIND_CLOSED) closed_reports++;
      else decay_reports++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected report: %s", report_text(got));
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("report %0d expected: %s", reports_seen, report_text(want));
            $display("report %0d actual:   %s", reports_seen, report_text(got));
          end
        end
      end
    end
  end

  // Output-side stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (rx_free) begin
      m_ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= ($urandom_range(0, 3) != 0);
        2: m_ready <= ((rx_tick % 9) < 5);
        default: m_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  function automatic longint unsigned rand_below(input longint unsigned lim);
    longint unsigned r;
    r = {$urandom, $urandom};
    return r % (lim + 1);
  endfunction

  function automatic void advance_stamp(input longint unsigned step);
    if ({16'd0, STAMP_MAX - stamp_now} < step) stamp_now = STAMP_MAX;
    else stamp_now = stamp_now + step[STAMP_W-1:0];
  endfunction

  task automatic send_event(input logic [FUNC_W-1:0] fn, input logic [XY_W-1:0] px, py,
                            input logic [STAMP_W-1:0] st, input logic [VAL16_W-1:0] tof, energy);
    int gap;
    gap = 0;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {4'd0, energy, tof, st, py, px};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    correlate_event(fn, px, py, st, tof, energy);
    events_sent++;
  endtask

  // Idle the input and wait until the block has delivered everything
  task automatic settle();
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [WINDOW_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW: window_q = val;
      CFG_COEF0:  coef0_q = val[COEF_W-1:0];
      CFG_COEF1:  coef1_q = val[COEF_W-1:0];
      default:    coef2_q = val[COEF_W-1:0];
    endcase
  endtask

  task automatic set_window(input logic [WINDOW_W-1:0] w);
    settle();
    write_reg(CFG_WINDOW, w);
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] c0, c1, c2);
    logic [31:0] junk;
    settle();
    junk = $urandom;
    write_reg(CFG_COEF0, {junk[7:0], c0});
    write_reg(CFG_COEF1, {junk[15:8], c1});
    write_reg(CFG_COEF2, {junk[23:16], c2});
  endtask

  function automatic void pick_hot();
    for (int i = 0; i < HOT; i++) begin
      hot_x[i] = XY_W'($urandom_range(0, GRID_DEF - 1));
      hot_y[i] = XY_W'($urandom_range(0, GRID_DEF - 1));
    end
    hot_x[0] = 6'd0;
    hot_y[0] = 6'd39;
    hot_x[1] = 6'd39;
    hot_y[1] = 6'd0;
  endfunction

  task automatic random_event(input longint unsigned span, output bit counted);
    logic [FUNC_W-1:0] fn;
    logic [XY_W-1:0] px, py;
    logic [STAMP_W-1:0] st;
    longint unsigned back;
    int r, h, s;
    counted = 1'b1;
    r = $urandom_range(0, 99);
    h = $urandom_range(0, HOT - 1);
    px = hot_x[h];
    py = hot_y[h];
    if ($urandom_range(0, 6) == 0) begin
      px = XY_W'($urandom_range(0, GRID_DEF - 1));
      py = XY_W'($urandom_range(0, GRID_DEF - 1));
    end
    if (r < 35) fn = FUNC_IMPLANT;
    else if (r < 83) fn = FUNC_DECAY;
    else if (r < 91) fn = FUNC_FLUSH;
    else begin
      // noise: unused func or a pixel off the grid
      counted = 1'b0;
      fn = FUNC_W'($urandom_range(0, 3));
      if (r < 95) fn = FUNC_UNUSED;
      else if (r < 97) px = XY_W'($urandom_range(GRID_DEF, 63));
      else if (r < 99) py = XY_W'($urandom_range(GRID_DEF, 63));
      else begin
        px = XY_W'($urandom_range(GRID_DEF, 63));
        py = XY_W'($urandom_range(GRID_DEF, 63));
      end
    end
    s = $urandom_range(0, 9);
    if (s < 6) advance_stamp(rand_below(span >> 4));
    else if (s < 9) advance_stamp(rand_below(span));
    else advance_stamp(rand_below(span * 3));
    st = stamp_now;
    if ($urandom_range(0, 49) == 0) begin
      back = rand_below(span);
      if ({16'd0, stamp_now} > back) st = stamp_now - back[STAMP_W-1:0];
    end
    send_event(fn, px, py, st, VAL16_W'($urandom_range(0, 65535)),
               VAL16_W'($urandom_range(0, 65535)));
  endtask

  task automatic run_random(input int count, input longint unsigned span);
    int n;
    bit counted;
    n = 0;
    pick_hot();
    while (n < count) begin
      random_event(span, counted);
      if (counted) n++;
    end
  endtask

  task automatic test_directed();
    send_event(FUNC_IMPLANT, 6'd0, 6'd0, 48'd1000, 16'd0, 16'd0);
    send_event(FUNC_DECAY, 6'd0, 6'd0, 48'd1000, 16'h5A5A, 16'hA5A5);
    send_event(FUNC_IMPLANT, 6'd39, 6'd39, 48'd1010, 16'hFFFF, 16'hFFFF);
    send_event(FUNC_DECAY, 6'd39, 6'd39, 48'd1020, 16'h1111, 16'h2222);
    // decay stamped before the implant, then a decay on an empty pixel
    send_event(FUNC_DECAY, 6'd39, 6'd39, 48'd1005, 16'd0, 16'd0);
    send_event(FUNC_DECAY, 6'd5, 6'd7, 48'd1030, 16'd0, 16'd0);
    // second implant blacklists, implant on blacklisted pixel restarts timer
    send_event(FUNC_IMPLANT, 6'd39, 6'd39, 48'd1030, 16'd77, 16'd88);
    send_event(FUNC_DECAY, 6'd39, 6'd39, 48'd1040, 16'd0, 16'd0);
    send_event(FUNC_IMPLANT, 6'd39, 6'd39, 48'd1050, 16'd99, 16'd11);
    send_event(FUNC_FLUSH, 6'd39, 6'd39, 48'd1060, 16'd0, 16'd0);
    send_event(FUNC_IMPLANT, 6'd39, 6'd39, 48'd1070, 16'd1234, 16'd4321);
    send_event(FUNC_FLUSH, 6'd39, 6'd39, 48'd1080, 16'd0, 16'd0);
    send_event(FUNC_FLUSH, 6'd39, 6'd39, 48'd1090, 16'd0, 16'd0);
    // off the grid and unused func
    send_event(FUNC_IMPLANT, 6'd40, 6'd0, 48'd1090, 16'd1, 16'd1);
    send_event(FUNC_IMPLANT, 6'd0, 6'd63, 48'd1090, 16'd1, 16'd1);
    send_event(FUNC_DECAY, 6'd63, 6'd63, 48'd1090, 16'd1, 16'd1);
    send_event(FUNC_UNUSED, 6'd0, 6'd0, 48'd1100, 16'd1, 16'd1);
    // exactly at the window edge, then one past it
    send_event(FUNC_DECAY, 6'd0, 6'd0, 48'd1000001000, 16'd0, 16'd0);
    send_event(FUNC_DECAY, 6'd0, 6'd0, 48'd1000001001, 16'd0, 16'd0);
    // blacklist expiry lets a new implant in
    send_event(FUNC_IMPLANT, 6'd1, 6'd1, 48'd2000000000, 16'd300, 16'd400);
    send_event(FUNC_IMPLANT, 6'd1, 6'd1, 48'd2000000000, 16'd301, 16'd401);
    send_event(FUNC_IMPLANT, 6'd1, 6'd1, 48'd3000000001, 16'd302, 16'd402);
    send_event(FUNC_DECAY, 6'd1, 6'd1, 48'd3000000005, 16'd0, 16'd0);
    stamp_now = 48'd3000000005;
  endtask

  task automatic test_window_expiry();
    logic [WINDOW_W-1:0] w;
    w = WINDOW_W'($urandom_range(16, 4096));
    set_window(w);
    run_random(500, w);
  endtask

  task automatic test_tof_coefficients();
    set_window(40'd100000);
    set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(100, 30000);
    set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    run_random(100, 30000);
    set_coefs($urandom, $urandom, $urandom);
    run_random(100, 30000);
    set_coefs($urandom, 32'd65536 + COEF_W'($urandom_range(0, 8191)) - 32'd4096,
              COEF_W'($urandom_range(0, 511)) - 32'd256);
    run_random(100, 30000);
    set_coefs(32'hFFFF_FFFF, 32'd0, 32'd0);
    run_random(100, 30000);
  endtask

  task automatic test_backpressure();
    bit counted;
    settle();
    pick_hot();
    for (int i = 0; i < 4; i++) begin
      send_event(FUNC_FLUSH, hot_x[i], hot_y[i], stamp_now, 16'd0, 16'd0);
      send_event(FUNC_IMPLANT, hot_x[i], hot_y[i], stamp_now, VAL16_W'($urandom),
                 VAL16_W'($urandom));
    end
    hold_req = 300;
    for (int i = 0; i < 80; i++) begin
      advance_stamp(1);
      send_event(FUNC_DECAY, hot_x[i % 4], hot_y[i % 4], stamp_now, 16'd0, 16'd0);
    end
    settle();
    for (int i = 0; i < 60; i++) random_event(5000, counted);
  endtask

  task automatic test_same_pixel_run();
    settle();
    tx_steady = 1'b1;
    rx_free = 1'b1;
    send_event(FUNC_FLUSH, 6'd20, 6'd21, stamp_now, 16'd0, 16'd0);
    send_event(FUNC_IMPLANT, 6'd20, 6'd21, stamp_now, 16'd4000, 16'd5000);
    repeat (STEADY_DECAYS) send_event(FUNC_DECAY, 6'd20, 6'd21, stamp_now, 16'd0, 16'd0);
    send_event(FUNC_FLUSH, 6'd20, 6'd21, stamp_now, 16'd0, 16'd0);
    settle();
    tx_steady = 1'b0;
    rx_free = 1'b0;
  endtask

  task automatic test_window_extremes();
    logic [63:0] r;
    set_window(40'd1);
    run_random(200, 3);
    set_window(WINDOW_MAX);
    r = {$urandom, $urandom};
    stamp_now = {1'b1, r[46:0]};
    run_random(200, 64'd1 << 40);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_window_expiry();
    test_tof_coefficients();
    test_backpressure();
    test_same_pixel_run();
    test_window_extremes();
    settle();
    $display("%0d events in, %0d reports checked (%0d decays, %0d closed implants)",
             events_sent, reports_seen, decay_reports, closed_reports);
    $display("covered: directed cases, expiry, TOF saturation, output hold-off, same-pixel run");
    if (mismatches == 0) begin
      $display("pixel_implant_decay_correlator: match");
    end else begin
      $display("pixel_implant_decay_correlator: mismatch");
    end
    $finish;
  end

endmodule
